// ----- design/http_status_line_parser_assert.svh -----
// Assertion macros used by the checker file of the status line parser.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef HTTP_STATUS_LINE_PARSER_ASSERT_SVH
`define HTTP_STATUS_LINE_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define HSP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define HSP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/hsp_pkg.sv -----
// Shared types and constants of the HTTP status line parser.
// No dependencies; every design module imports this package.
package hsp_pkg;

	localparam int MAX_LINE_LEN = 4096;
	localparam int POS_W        = $clog2(MAX_LINE_LEN + 1);
	localparam int OFS_W        = 13;
	localparam int ACC_W        = 10;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [7:0] CH_H     = 8'h48;
	localparam logic [7:0] CH_T     = 8'h54;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_VIS_LO = 8'h21;
	localparam logic [7:0] CH_VIS_HI = 8'h7E;

	localparam logic [ACC_W-1:0] ACC_MAX    = 10'd1023;
	localparam logic [ACC_W-1:0] VER_MAX    = 10'd9;
	localparam logic [ACC_W-1:0] STATUS_MIN = 10'd100;
	localparam logic [ACC_W-1:0] STATUS_MAX = 10'd599;

	typedef enum logic [2:0] {
		ERR_NONE     = 3'd0,
		ERR_SYNTAX   = 3'd1,
		ERR_VERSION  = 3'd2,
		ERR_STATUS   = 3'd3,
		ERR_EARLY    = 3'd4,
		ERR_TOO_LONG = 3'd5
	} err_t;

	typedef enum logic [14:0] {
		PH_IDLE  = 15'h0001,
		PH_H     = 15'h0002,
		PH_T1    = 15'h0004,
		PH_T2    = 15'h0008,
		PH_P     = 15'h0010,
		PH_SLASH = 15'h0020,
		PH_MAJ0  = 15'h0040,
		PH_MAJ   = 15'h0080,
		PH_MIN0  = 15'h0100,
		PH_MIN   = 15'h0200,
		PH_ST0   = 15'h0400,
		PH_ST    = 15'h0800,
		PH_RS0   = 15'h1000,
		PH_RS    = 15'h2000,
		PH_DONE  = 15'h4000
	} phase_t;

	// One classified byte as it travels from the front to the back.
	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
		logic       digit;
		logic       in_set;
	} beat_t;

	// Head of the queue as the back sees it.
	typedef struct packed {
		logic  valid;
		beat_t beat;
	} q_head_t;

endpackage

// ----- design/hsp_front.sv -----
// Front end: takes input beats and classifies each byte for the parser.
// Depends on hsp_pkg; pushes into hsp_queue.
module hsp_front
	import hsp_pkg::*;
(
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       first,
	input  logic       last,
	input  logic       q_full,
	output logic       push,
	output beat_t      push_beat
);

	logic is_digit;
	logic is_vis;

	assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign is_vis   = (data_byte >= CH_VIS_LO) && (data_byte <= CH_VIS_HI);

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_beat.data   = data_byte;
		push_beat.first  = first;
		push_beat.last   = last;
		push_beat.digit  = is_digit;
		push_beat.in_set = is_vis || (data_byte == CH_TAB) || (data_byte == CH_SP);
	end

endmodule

// ----- design/hsp_queue.sv -----
// Short queue of classified beats between the front and the back.
// Depends on hsp_pkg.
module hsp_queue
	import hsp_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  beat_t   push_beat,
	output logic    full,
	input  logic    pop,
	output q_head_t head
);

	beat_t             mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] ptr);
		return (ptr == QPTR_W'(QDEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
	endfunction

	assign full       = (count_q == QCNT_W'(QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.beat  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_beat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- design/hsp_back.sv -----
// Back end: the status line state machine and the result register; it takes one beat
// per cycle while no result is stalled. Depends on hsp_pkg; pops beats from hsp_queue.
module hsp_back
	import hsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  q_head_t          head,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             ok,
	output logic [2:0]       error_code,
	output logic [3:0]       version_major,
	output logic [3:0]       version_minor,
	output logic [9:0]       status_value,
	output logic [OFS_W-1:0] status_end,
	output logic             has_reason,
	output logic [OFS_W-1:0] reason_begin,
	output logic [OFS_W-1:0] reason_end,
	output logic [OFS_W-1:0] consumed
);

	phase_t             phase_q;
	logic [ACC_W-1:0]   acc_q;
	logic [ACC_W-1:0]   major_q;
	logic [POS_W-1:0]   pos_q;
	logic [7:0]         ver_q;
	logic [ACC_W-1:0]   status_q;
	logic [POS_W-1:0]   line_end_q;
	logic [POS_W-1:0]   rstart_q;
	logic [1:0]         flags_q;

	phase_t             ph;
	logic [ACC_W-1:0]   acc;
	logic [ACC_W-1:0]   maj;
	logic [POS_W-1:0]   pos;
	logic [POS_W-1:0]   p;
	logic [7:0]         ver;
	logic [ACC_W-1:0]   st;
	logic [POS_W-1:0]   lend;
	logic [POS_W-1:0]   rst;
	logic [1:0]         flg;
	logic               active;
	logic               fire;
	logic               okv;
	err_t               err;
	logic               has;
	beat_t              b;

	logic               out_valid_q;
	logic               ok_q;
	logic [2:0]         err_q;
	logic [3:0]         vmaj_q;
	logic [3:0]         vmin_q;
	logic [9:0]         stc_q;
	logic [OFS_W-1:0]   send_q;
	logic               has_q;
	logic [OFS_W-1:0]   rbeg_q;
	logic [OFS_W-1:0]   rend_q;
	logic [OFS_W-1:0]   cons_q;

	logic               r_ok;
	logic [3:0]         r_vmaj;
	logic [3:0]         r_vmin;
	logic [9:0]         r_stc;
	logic [OFS_W-1:0]   r_send;
	logic [OFS_W-1:0]   r_rbeg;
	logic [OFS_W-1:0]   r_rend;
	logic [OFS_W-1:0]   r_cons;

	// Decimal accumulate with saturation: acc * 10 + d, capped at ACC_MAX.
	function automatic logic [ACC_W-1:0] mul10_add(input logic [ACC_W-1:0] a,
			input logic [3:0] d);
		logic [ACC_W+3:0] v;
		v = (ACC_W+4)'({a, 3'b000}) + (ACC_W+4)'({a, 1'b0}) + (ACC_W+4)'(d);
		return (v > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
	endfunction

	assign b   = head.beat;
	assign pop = head.valid && (!out_valid_q || out_ready);

	always_comb begin
		ph     = phase_q;
		acc    = acc_q;
		maj    = major_q;
		pos    = pos_q;
		p      = pos_q;
		ver    = ver_q;
		st     = status_q;
		lend   = line_end_q;
		rst    = rstart_q;
		flg    = flags_q;
		fire   = 1'b0;
		okv    = 1'b0;
		err    = ERR_NONE;
		active = (phase_q != PH_IDLE) && (phase_q != PH_DONE);

		if (b.first) begin
			ph     = PH_H;
			acc    = '0;
			maj    = '0;
			pos    = '0;
			ver    = '0;
			st     = '0;
			lend   = '0;
			rst    = '0;
			flg    = '0;
			active = 1'b1;
		end

		if (active) begin
			if (((ph == PH_RS0) || (ph == PH_RS)) && !b.in_set) begin
				// The byte that ends the reason phrase is not consumed.
				fire = 1'b1;
				okv  = 1'b1;
			end else if (pos >= POS_W'(MAX_LINE_LEN)) begin
				fire = 1'b1;
				err  = ERR_TOO_LONG;
			end else begin
				p   = pos;
				pos = p + POS_W'(1);
				case (ph)
					PH_H: begin
						if (b.data != CH_H) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else ph = PH_T1;
					end
					PH_T1: begin
						if (b.data != CH_T) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else ph = PH_T2;
					end
					PH_T2: begin
						if (b.data != CH_T) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else ph = PH_P;
					end
					PH_P: begin
						if (b.data != CH_P) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else ph = PH_SLASH;
					end
					PH_SLASH: begin
						if (b.data != CH_SLASH) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else ph = PH_MAJ0;
					end
					PH_MAJ0: begin
						if (!b.digit) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else begin
							acc = ACC_W'(b.data[3:0]);
							ph  = PH_MAJ;
						end
					end
					PH_MIN0: begin
						if (!b.digit) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else begin
							acc = ACC_W'(b.data[3:0]);
							ph  = PH_MIN;
						end
					end
					PH_ST0: begin
						if (!b.digit) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else begin
							acc = ACC_W'(b.data[3:0]);
							ph  = PH_ST;
						end
					end
					PH_MAJ: begin
						if (b.digit) begin
							acc = mul10_add(acc, b.data[3:0]);
						end else if (b.data != CH_DOT) begin
							fire = 1'b1; err = ERR_SYNTAX;
						end else begin
							maj = acc;
							acc = '0;
							ph  = PH_MIN0;
						end
					end
					PH_MIN: begin
						if (b.digit) begin
							acc = mul10_add(acc, b.data[3:0]);
						end else if ((maj > VER_MAX) || (acc > VER_MAX)) begin
							fire = 1'b1; err = ERR_VERSION;
						end else begin
							ver    = {maj[3:0], acc[3:0]};
							flg[0] = 1'b1;
							if (b.data != CH_SP) begin
								fire = 1'b1; err = ERR_SYNTAX;
							end else begin
								acc = '0;
								ph  = PH_ST0;
							end
						end
					end
					PH_ST: begin
						if (b.digit) begin
							acc = mul10_add(acc, b.data[3:0]);
						end else if ((acc < STATUS_MIN) || (acc > STATUS_MAX)) begin
							fire = 1'b1; err = ERR_STATUS;
						end else begin
							st     = acc;
							lend   = p;
							flg[1] = 1'b1;
							if (b.data != CH_SP) begin
								fire = 1'b1; err = ERR_SYNTAX;
							end else ph = PH_RS0;
						end
					end
					PH_RS0: begin
						rst = p;
						ph  = PH_RS;
					end
					default: begin
					end
				endcase

				if (!fire && b.last) begin
					fire = 1'b1;
					if ((ph == PH_RS0) || (ph == PH_RS)) begin
						okv = 1'b1;
					end else if (ph == PH_MIN) begin
						if ((maj > VER_MAX) || (acc > VER_MAX)) begin
							err = ERR_VERSION;
						end else begin
							ver    = {maj[3:0], acc[3:0]};
							flg[0] = 1'b1;
							err    = ERR_EARLY;
						end
					end else if (ph == PH_ST) begin
						if ((acc < STATUS_MIN) || (acc > STATUS_MAX)) begin
							err = ERR_STATUS;
						end else begin
							st     = acc;
							lend   = pos;
							flg[1] = 1'b1;
							err    = ERR_EARLY;
						end
					end else begin
						err = ERR_EARLY;
					end
				end
			end
		end

		has    = okv && (ph == PH_RS);
		r_ok   = okv;
		r_vmaj = flg[0] ? ver[7:4] : 4'd0;
		r_vmin = flg[0] ? ver[3:0] : 4'd0;
		r_stc  = flg[1] ? st : '0;
		r_send = has ? OFS_W'(pos) : OFS_W'(lend);
		r_rbeg = has ? OFS_W'(rst) : '0;
		r_rend = has ? OFS_W'(pos) : '0;
		r_cons = okv ? OFS_W'(pos) : '0;
		if (fire) begin
			ph = PH_DONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= ph;
			end
			if (pop && fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			acc_q      <= acc;
			major_q    <= maj;
			pos_q      <= pos;
			ver_q      <= ver;
			status_q   <= st;
			line_end_q <= lend;
			rstart_q   <= rst;
			flags_q    <= flg;
		end
		if (pop && fire) begin
			ok_q   <= r_ok;
			err_q  <= err;
			vmaj_q <= r_vmaj;
			vmin_q <= r_vmin;
			stc_q  <= r_stc;
			send_q <= r_send;
			has_q  <= has;
			rbeg_q <= r_rbeg;
			rend_q <= r_rend;
			cons_q <= r_cons;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign error_code    = err_q;
	assign version_major = vmaj_q;
	assign version_minor = vmin_q;
	assign status_value  = stc_q;
	assign status_end    = send_q;
	assign has_reason    = has_q;
	assign reason_begin  = rbeg_q;
	assign reason_end    = rend_q;
	assign consumed      = cons_q;

endmodule

// ----- design/http_status_line_parser.sv -----
// HTTP status line parser: takes the bytes of a response, one beat per byte, and
// gives one result beat per status line.
// Input channel: in_valid/in_ready carry data_byte, first and last. A beat with
// first set restarts the parse at offset 0; last marks the end of the text.
// Output channel: out_valid/out_ready carry ok, error_code, the version, the
// status code and the byte offsets of the line and of its reason phrase.
// Throughput is one byte per cycle while no result is stalled, set by the per-byte
// step of the back end's state machine, which does one saturating multiply-by-ten
// and add per cycle. An accepted input beat is written into the queue; the back
// end pops it and, if it ends a line, registers the result that drives out_valid.
// Bytes that arrive while no line is open produce no result and are dropped.
// At reset the queue empties, the parser goes idle and no result is pending.
// When the receiver stalls, the pending result holds steady and the back end takes
// no further beats until it is taken, whether or not the next byte would give a
// result; once the two-entry queue fills, in_ready falls.
// Depends on hsp_pkg, hsp_front, hsp_queue and hsp_back.
module http_status_line_parser
	import hsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       data_byte,
	input  logic             first,
	input  logic             last,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             ok,
	output logic [2:0]       error_code,
	output logic [3:0]       version_major,
	output logic [3:0]       version_minor,
	output logic [9:0]       status_value,
	output logic [OFS_W-1:0] status_end,
	output logic             has_reason,
	output logic [OFS_W-1:0] reason_begin,
	output logic [OFS_W-1:0] reason_end,
	output logic [OFS_W-1:0] consumed
);

	// Classified beats pass from the front through the queue to the back.
	logic    push;
	beat_t   push_beat;
	logic    q_full;
	logic    pop;
	q_head_t head;

	hsp_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.first     (first),
		.last      (last),
		.q_full    (q_full),
		.push      (push),
		.push_beat (push_beat)
	);

	hsp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_beat (push_beat),
		.full      (q_full),
		.pop       (pop),
		.head      (head)
	);

	// The back end pops a beat whenever its result register is free or being taken.
	hsp_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.ok            (ok),
		.error_code    (error_code),
		.version_major (version_major),
		.version_minor (version_minor),
		.status_value  (status_value),
		.status_end    (status_end),
		.has_reason    (has_reason),
		.reason_begin  (reason_begin),
		.reason_end    (reason_end),
		.consumed      (consumed)
	);

endmodule

// ----- design/hsp_checker.sv -----
// Port-level checks on the status line parser, bound to its top level.
// Depends on hsp_pkg and http_status_line_parser_assert.svh.
`include "http_status_line_parser_assert.svh"

module hsp_checker
	import hsp_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic             ok,
	input logic [2:0]       error_code,
	input logic [3:0]       version_major,
	input logic [3:0]       version_minor,
	input logic [9:0]       status_value,
	input logic             has_reason,
	input logic [OFS_W-1:0] consumed
);

	`HSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
		out_valid && $stable(error_code) && $stable(status_value) && $stable(consumed),
		"result beat changed while stalled")

	`HSP_ASSERT_NOW(a_ok_no_error, out_valid && ok,
		error_code == ERR_NONE, "successful result carries an error code")

	`HSP_ASSERT_NOW(a_fail_fields, out_valid && !ok,
		consumed == '0 && has_reason == 1'b0 && error_code != ERR_NONE,
		"failed result reports consumed bytes or a reason phrase")

	`HSP_ASSERT_NOW(a_ok_ranges, out_valid && ok,
		status_value >= 10'd100 && status_value <= 10'd599 &&
		version_major <= 4'd9 && version_minor <= 4'd9,
		"successful result with version or status out of range")

endmodule

bind http_status_line_parser hsp_checker u_hsp_checker (.*);

// ----- test/http_status_line_parser_test.sv -----
// Self-checking testbench for the HTTP status line parser: directed lines, a receiver hold-off,
// drain pauses, lines at the length limit and random lines, checked against a built-in predictor.
// Depends on hsp_pkg and http_status_line_parser only.
module http_status_line_parser_test
	import hsp_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_PERIOD   = 12;
	localparam int RESET_CYCLES = 11;
	localparam int RANDOM_ITEMS = 1600;
	localparam int HOLD_CYCLES  = 400;
	localparam int IDLE_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int NO_TAIL      = -1;

	// Limits of the status line grammar, kept apart from the design's own copies.
	localparam int unsigned ACCUM_CAP   = 1023;
	localparam int unsigned VERSION_TOP = 9;
	localparam int unsigned STATUS_LOW  = 100;
	localparam int unsigned STATUS_HIGH = 599;

	localparam logic [7:0] TAB_CHAR   = 8'h09;
	localparam logic [7:0] CR_CHAR    = 8'h0D;
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] PRINT_LO   = 8'h21;
	localparam logic [7:0] PRINT_HI   = 8'h7E;

	typedef logic [7:0] text_q_t [$];

	// One status line verdict, in the order of the output ports.
	typedef struct packed {
		logic             ok;
		logic [2:0]       err;
		logic [3:0]       vmaj;
		logic [3:0]       vmin;
		logic [9:0]       status;
		logic [OFS_W-1:0] status_end;
		logic             has_reason;
		logic [OFS_W-1:0] rbeg;
		logic [OFS_W-1:0] rend;
		logic [OFS_W-1:0] consumed;
	} line_result_t;

	// How the receiver behaves between hold-offs.
	typedef enum int {
		RX_ALWAYS,
		RX_HALF,
		RX_MOSTLY,
		RX_SPARSE
	} rx_mode_t;

	// How a random line is brought to an end.
	typedef enum int {
		END_CR,
		END_OTHER,
		END_LAST,
		END_CUT_LAST,
		END_CUT_OPEN,
		END_JUNK
	} line_end_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [7:0]       data_byte = 8'h00;
	logic             first = 1'b0;
	logic             last = 1'b0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             ok;
	logic [2:0]       error_code;
	logic [3:0]       version_major;
	logic [3:0]       version_minor;
	logic [9:0]       status_value;
	logic [OFS_W-1:0] status_end;
	logic             has_reason;
	logic [OFS_W-1:0] reason_begin;
	logic [OFS_W-1:0] reason_end;
	logic [OFS_W-1:0] consumed;

	// Predicted verdicts still waiting for the block to deliver them, oldest first.
	line_result_t expected_results [$];

	// Predictor state: a private copy of the parser's registers.
	phase_t      ph_state = PH_IDLE;
	int unsigned accum = 0;
	int unsigned major_num = 0;
	int unsigned pos = 0;
	int unsigned line_end = 0;
	int unsigned reason_at = 0;
	logic [3:0]  ver_hi = 4'd0;
	logic [3:0]  ver_lo = 4'd0;
	logic [9:0]  status_val = 10'd0;
	bit          ver_ok = 1'b0;
	bit          status_ok = 1'b0;

	// Sender burst control.
	bit gaps_on = 1'b1;
	int burst_left = 0;

	// Receiver control. The hold-off request is raised by the test sequence and counted
	// down by the receiver in its own process.
	int       hold_requests = 0;
	int       hold_seen = 0;
	int       hold_left = 0;
	rx_mode_t rx_mode = RX_ALWAYS;
	int       rx_mode_left = 0;

	// Bookkeeping for the summary.
	int mismatches = 0;
	int results_seen = 0;
	int ok_count = 0;
	int err_seen [0:7];
	int lines_sent = 0;
	int bytes_sent = 0;
	int parsed_bytes = 0;
	int idle_cycles = 0;

	http_status_line_parser i_dut (.*);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ---------------------------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------------------------

	function automatic void clear_state();
		ph_state = PH_IDLE;
		accum = 0;
		major_num = 0;
		pos = 0;
		line_end = 0;
		reason_at = 0;
		ver_hi = 4'd0;
		ver_lo = 4'd0;
		status_val = 10'd0;
		ver_ok = 1'b0;
		status_ok = 1'b0;
	endfunction

	// Decimal accumulation that sticks at the top of the ten-bit range.
	function automatic int unsigned times_ten_plus(input int unsigned acc, input int unsigned d);
		int unsigned v;
		v = acc * 10 + d;
		return (v > ACCUM_CAP) ? ACCUM_CAP : v;
	endfunction

	// Both version numbers must be single digits; on success they are latched.
	function automatic bit version_fits();
		if (major_num > VERSION_TOP || accum > VERSION_TOP) begin
			return 1'b0;
		end
		ver_hi = major_num[3:0];
		ver_lo = accum[3:0];
		ver_ok = 1'b1;
		return 1'b1;
	endfunction

	// The status code must lie between 100 and 599; on success it is latched with
	// the offset just past its digits.
	function automatic bit status_fits(input int unsigned end_ofs);
		if (accum < STATUS_LOW || accum > STATUS_HIGH) begin
			return 1'b0;
		end
		status_val = accum[9:0];
		line_end = end_ofs;
		status_ok = 1'b1;
		return 1'b1;
	endfunction

	// Builds the verdict from the current state and closes the line.
	function automatic line_result_t close_line(input bit good, input err_t code);
		line_result_t r;
		bit with_reason;
		with_reason = good && ph_state == PH_RS;
		r.ok = good;
		r.err = code;
		r.vmaj = ver_ok ? ver_hi : 4'd0;
		r.vmin = ver_ok ? ver_lo : 4'd0;
		r.status = status_ok ? status_val : 10'd0;
		r.status_end = OFS_W'(with_reason ? pos : line_end);
		r.has_reason = with_reason;
		r.rbeg = with_reason ? OFS_W'(reason_at) : '0;
		r.rend = with_reason ? OFS_W'(pos) : '0;
		r.consumed = good ? OFS_W'(pos) : '0;
		ph_state = PH_DONE;
		return r;
	endfunction

	// Advances the predicted parse by one byte. Returns 1 when this byte makes a verdict.
	function automatic bit parse_step(input logic [7:0] c, input bit frst, input bit lst,
			output line_result_t r);
		bit digit;
		bit in_set;
		bit fail;
		err_t code;
		int unsigned p;
		int unsigned d;
		r = '0;
		fail = 1'b0;
		code = ERR_SYNTAX;
		digit = c >= "0" && c <= "9";
		in_set = (c >= PRINT_LO && c <= PRINT_HI) || c == TAB_CHAR || c == SPACE_CHAR;
		d = c[3:0];

		if (frst) begin
			clear_state();
			ph_state = PH_H;
		end else if (ph_state == PH_IDLE || ph_state == PH_DONE) begin
			return 1'b0;
		end

		// A byte outside the reason set ends the line successfully without being consumed,
		// so this comes ahead of the length limit.
		if ((ph_state == PH_RS0 || ph_state == PH_RS) && !in_set) begin
			r = close_line(1'b1, ERR_NONE);
			return 1'b1;
		end
		if (pos >= MAX_LINE_LEN) begin
			r = close_line(1'b0, ERR_TOO_LONG);
			return 1'b1;
		end
		p = pos;
		pos = p + 1;

		case (ph_state)
			PH_H: begin
				if (c != "H") fail = 1'b1;
				else ph_state = PH_T1;
			end
			PH_T1: begin
				if (c != "T") fail = 1'b1;
				else ph_state = PH_T2;
			end
			PH_T2: begin
				if (c != "T") fail = 1'b1;
				else ph_state = PH_P;
			end
			PH_P: begin
				if (c != "P") fail = 1'b1;
				else ph_state = PH_SLASH;
			end
			PH_SLASH: begin
				if (c != "/") fail = 1'b1;
				else ph_state = PH_MAJ0;
			end
			PH_MAJ0, PH_MIN0, PH_ST0: begin
				if (!digit) begin
					fail = 1'b1;
				end else begin
					accum = d;
					ph_state = (ph_state == PH_MAJ0) ? PH_MAJ :
						((ph_state == PH_MIN0) ? PH_MIN : PH_ST);
				end
			end
			PH_MAJ: begin
				if (digit) begin
					accum = times_ten_plus(accum, d);
				end else if (c != ".") begin
					fail = 1'b1;
				end else begin
					major_num = accum;
					accum = 0;
					ph_state = PH_MIN0;
				end
			end
			PH_MIN: begin
				// The version check runs before the terminating byte is examined.
				if (digit) begin
					accum = times_ten_plus(accum, d);
				end else if (!version_fits()) begin
					fail = 1'b1;
					code = ERR_VERSION;
				end else if (c != " ") begin
					fail = 1'b1;
				end else begin
					accum = 0;
					ph_state = PH_ST0;
				end
			end
			PH_ST: begin
				if (digit) begin
					accum = times_ten_plus(accum, d);
				end else if (!status_fits(p)) begin
					fail = 1'b1;
					code = ERR_STATUS;
				end else if (c != " ") begin
					fail = 1'b1;
				end else begin
					ph_state = PH_RS0;
				end
			end
			PH_RS0: begin
				reason_at = p;
				ph_state = PH_RS;
			end
			default: begin
			end
		endcase

		if (fail) begin
			r = close_line(1'b0, code);
			return 1'b1;
		end
		if (!lst) begin
			return 1'b0;
		end
		// End of input: complete after the second space, otherwise any pending number
		// check gets its say before the line is called short.
		if (ph_state == PH_RS0 || ph_state == PH_RS) r = close_line(1'b1, ERR_NONE);
		else if (ph_state == PH_MIN && !version_fits()) r = close_line(1'b0, ERR_VERSION);
		else if (ph_state == PH_ST && !status_fits(pos)) r = close_line(1'b0, ERR_STATUS);
		else r = close_line(1'b0, ERR_EARLY);
		return 1'b1;
	endfunction

	// ---------------------------------------------------------------------------------
	// Checking
	// ---------------------------------------------------------------------------------

	task automatic report_mismatch(input string what, input logic [15:0] got_v,
			input logic [15:0] want_v);
		$display("MISMATCH at %0t, result %0d: %s got %0d expected %0d",
			$realtime, results_seen, what, got_v, want_v);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got_v,
			input logic [15:0] want_v);
		if (got_v !== want_v) begin
			report_mismatch(name, got_v, want_v);
		end
	endtask

	// Every result beat is taken at the edge where it is accepted; values read here are
	// the ones the block held up to that edge.
	always @(posedge clk) begin : check_results
		line_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with nothing pending", 16'd1, 16'd0);
			end else begin
				want = expected_results.pop_front();
				if (want.ok) ok_count++;
				else err_seen[want.err]++;
				check_field("ok", 16'(ok), 16'(want.ok));
				check_field("error_code", 16'(error_code), 16'(want.err));
				check_field("version_major", 16'(version_major), 16'(want.vmaj));
				check_field("version_minor", 16'(version_minor), 16'(want.vmin));
				check_field("status_value", 16'(status_value), 16'(want.status));
				check_field("status_end", 16'(status_end), 16'(want.status_end));
				check_field("has_reason", 16'(has_reason), 16'(want.has_reason));
				check_field("reason_begin", 16'(reason_begin), 16'(want.rbeg));
				check_field("reason_end", 16'(reason_end), 16'(want.rend));
				check_field("consumed", 16'(consumed), 16'(want.consumed));
			end
		end
	end

	// Ends the run if neither channel moves a beat for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog: no beat accepted for %0d cycles, %0d results outstanding",
				idle_cycles, expected_results.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------
	// Receiver: a requested hold-off takes priority, otherwise a randomly chosen mode
	// that is redrawn at random whenever its run ends.
	// ---------------------------------------------------------------------------------

	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = rx_mode_t'($urandom_range(0, 3));
				rx_mode_left = $urandom_range(20, 200);
			end
			rx_mode_left--;
			case (rx_mode)
				RX_ALWAYS: out_ready <= 1'b1;
				RX_HALF:   out_ready <= $urandom_range(0, 1) == 1;
				RX_MOSTLY: out_ready <= $urandom_range(0, 9) != 0;
				default:   out_ready <= $urandom_range(0, 9) < 2;
			endcase
		end
	end

	// ---------------------------------------------------------------------------------
	// Sender
	// ---------------------------------------------------------------------------------

	// Offers one byte and returns at the edge where it is taken, then predicts it. Valid
	// is only dropped between bursts, so back-to-back beats keep it high.
	task automatic send_byte(input logic [7:0] c, input bit frst, input bit lst);
		line_result_t r;
		if (gaps_on && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0) burst_left--;
		in_valid <= 1'b1;
		data_byte <= c;
		first <= frst;
		last <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		bytes_sent++;
		if (frst) lines_sent++;
		// Only bytes that reach an open parse count towards the random quota.
		if (frst || (ph_state != PH_IDLE && ph_state != PH_DONE)) parsed_bytes++;
		if (parse_step(c, frst, lst, r)) begin
			expected_results.push_back(r);
		end
	endtask

	// The first byte of a queue starts a line; the final one carries last if asked.
	task automatic send_bytes(input text_q_t q, input bit end_mark);
		foreach (q[i]) begin
			send_byte(q[i], i == 0, end_mark && i == q.size() - 1);
		end
	endtask

	function automatic text_q_t to_bytes(input string s);
		text_q_t q;
		int i;
		for (i = 0; i < s.len(); i++) q.push_back(s[i]);
		return q;
	endfunction

	task automatic send_line(input string s, input int tail, input bit end_mark);
		text_q_t q;
		q = to_bytes(s);
		if (tail != NO_TAIL) q.push_back(tail[7:0]);
		send_bytes(q, end_mark);
	endtask

	// Stops offering bytes until every predicted result has been delivered.
	task automatic wait_drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	// ---------------------------------------------------------------------------------
	// Random line generation
	// ---------------------------------------------------------------------------------

	function automatic string number_text(input int unsigned v);
		string s;
		s = $sformatf("%0d", v);
		if ($urandom_range(0, 9) == 0) s = {"00", s};
		return s;
	endfunction

	function automatic int unsigned pick_version();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 120) : $urandom_range(0, 9);
	endfunction

	function automatic int unsigned pick_status();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return $urandom_range(0, 99);
		if (r == 1) return $urandom_range(600, 1100);
		if (r == 2) return $urandom_range(10000, 99999);
		return $urandom_range(STATUS_LOW, STATUS_HIGH);
	endfunction

	function automatic logic [7:0] reason_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return TAB_CHAR;
		if (r == 1) return SPACE_CHAR;
		return 8'($urandom_range(PRINT_LO, PRINT_HI));
	endfunction

	// Any byte that cannot belong to a reason phrase.
	function automatic logic [7:0] outside_byte();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) return 8'($urandom_range(8'h00, 8'h08));
		if (r == 1) return 8'($urandom_range(8'h0A, 8'h1F));
		return 8'($urandom_range(8'h7F, 8'hFF));
	endfunction

	// Mostly well-formed status lines with random numbers and reasons, some with a
	// corrupted byte, cut short or left open; a small share is pure noise.
	function automatic void build_line(output text_q_t q, output bit end_mark);
		string s;
		int n;
		int cut;
		line_end_t ending;
		q = {};
		end_mark = 1'b0;
		if ($urandom_range(0, 99) < 8) begin
			n = $urandom_range(1, 10);
			repeat (n) q.push_back(8'($urandom_range(0, 255)));
			end_mark = $urandom_range(0, 1) == 1;
			return;
		end
		s = {"HTTP/", number_text(pick_version()), ".", number_text(pick_version()), " ",
			number_text(pick_status()), " "};
		q = to_bytes(s);
		n = $urandom_range(0, 10);
		repeat (n) q.push_back(reason_byte());
		if ($urandom_range(0, 99) < 15) begin
			q[$urandom_range(0, q.size() - 1)] = 8'($urandom_range(0, 255));
		end
		ending = line_end_t'($urandom_range(0, 5));
		case (ending)
			END_CR:    q.push_back(CR_CHAR);
			END_OTHER: q.push_back(outside_byte());
			END_LAST:  end_mark = 1'b1;
			END_CUT_LAST, END_CUT_OPEN: begin
				cut = $urandom_range(1, q.size());
				while (q.size() > cut) q.delete(q.size() - 1);
				end_mark = ending == END_CUT_LAST;
			end
			default: begin
				// Trailing bytes after the verdict must be dropped by the block.
				q.push_back(CR_CHAR);
				repeat ($urandom_range(1, 4)) q.push_back(8'($urandom_range(0, 255)));
				end_mark = $urandom_range(0, 1) == 1;
			end
		endcase
	endfunction

	// ---------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------

	// Hand-picked lines: good lines with and without reason, every error code but
	// ERR_TOO_LONG, the order of checks, restarts and bytes that must be ignored.
	task automatic test_directed();
		// Nothing has started yet, so these are dropped.
		send_byte("A", 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h00, 1'b0, 1'b0);
		send_line("HTTP/1.1 200 OK", CR_CHAR, 1'b0);
		send_line("HTTP/1.0 404 ", CR_CHAR, 1'b0);
		send_line("HTTP/9.9 599 x", NO_TAIL, 1'b1);
		send_line("HTTP/0.0 100 ", NO_TAIL, 1'b1);
		send_line("HTTP/01.001 302 Found it\t!~", 8'h7F, 1'b0);
		send_line("HTTP/1.1 500 x", 8'hFF, 1'b0);
		send_line("HTTP/10.1 200 OK", CR_CHAR, 1'b0);
		send_line("HTTP/1.12 200 OK", CR_CHAR, 1'b0);
		send_line("HTTP/1.1 099 X", CR_CHAR, 1'b0);
		send_line("HTTP/1.1 600 X", CR_CHAR, 1'b0);
		// Saturating accumulator still fails the range check.
		send_line("HTTP/1.1 99999999 X", CR_CHAR, 1'b0);
		send_line("HTTP/1.1 200", NO_TAIL, 1'b1);
		send_line("HTTP/1.1 700", NO_TAIL, 1'b1);
		send_line("HTTP/1.1", NO_TAIL, 1'b1);
		send_line("HTTP/1.10", NO_TAIL, 1'b1);
		send_line("HTTP/1.1 ", NO_TAIL, 1'b1);
		send_line("HTTP/1.x", NO_TAIL, 1'b0);
		send_line("HTTP/.1 200", NO_TAIL, 1'b0);
		send_line("HTTX", NO_TAIL, 1'b0);
		// A good number followed by the wrong separator is still a syntax error.
		send_line("HTTP/1.1", TAB_CHAR, 1'b0);
		send_line("HTTP/1.1 200", TAB_CHAR, 1'b0);
		send_line("H", NO_TAIL, 1'b1);
		// An unfinished line is abandoned by the next first byte.
		send_line("HTTP/1.", NO_TAIL, 1'b0);
		send_line("HTTP/2.0 204 No Content", CR_CHAR, 1'b0);
		send_byte("x", 1'b0, 1'b0);
		send_byte(8'hFF, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1, 1'b1);
	endtask

	// The receiver holds off for a long stretch while the sender keeps going flat out,
	// so the result path backs up and the input has to stall.
	task automatic test_receiver_hold();
		text_q_t q;
		bit end_mark;
		gaps_on = 1'b0;
		hold_requests <= hold_requests + 1;
		repeat (20) begin
			build_line(q, end_mark);
			send_bytes(q, end_mark);
		end
		gaps_on = 1'b1;
	endtask

	// A few lines at a time, each group followed by a full drain of the results.
	task automatic test_drain_pause();
		text_q_t q;
		bit end_mark;
		repeat (3) begin
			repeat (4) begin
				build_line(q, end_mark);
				send_bytes(q, end_mark);
			end
			wait_drain();
		end
	endtask

	// Lines that run into the length limit: one byte too many in the reason phrase, and
	// a full-length reason ended by a byte that is not consumed.
	task automatic test_length_limit();
		text_q_t q;
		gaps_on = 1'b0;
		q = to_bytes("HTTP/1.1 200 ");
		while (q.size() < MAX_LINE_LEN) q.push_back(8'($urandom_range(PRINT_LO, PRINT_HI)));
		q.push_back("z");
		send_bytes(q, 1'b0);
		q = to_bytes("HTTP/1.0 301 ");
		while (q.size() < MAX_LINE_LEN) q.push_back(reason_byte());
		q.push_back(CR_CHAR);
		send_bytes(q, 1'b0);
		gaps_on = 1'b1;
	endtask

	// Random lines until enough bytes have gone through the parser, with the sender's
	// bursts switched on and off now and then.
	task automatic test_random_lines();
		text_q_t q;
		bit end_mark;
		parsed_bytes = 0;
		while (parsed_bytes < RANDOM_ITEMS) begin
			if ($urandom_range(0, 9) == 0) gaps_on = !gaps_on;
			build_line(q, end_mark);
			send_bytes(q, end_mark);
		end
	endtask

	initial begin
		foreach (err_seen[i]) err_seen[i] = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_receiver_hold();
		test_drain_pause();
		test_length_limit();
		test_random_lines();
		wait_drain();
		// Anything the block delivers beyond the predictions shows up in this window.
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Covered %0d lines, %0d bytes, %0d random bytes parsed, %0d results checked",
			lines_sent, bytes_sent, parsed_bytes, results_seen);
		$display("Verdicts: %0d ok, syntax %0d, version %0d, status %0d, early %0d, long %0d",
			ok_count, err_seen[ERR_SYNTAX], err_seen[ERR_VERSION], err_seen[ERR_STATUS],
			err_seen[ERR_EARLY], err_seen[ERR_TOO_LONG]);
		if (mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/hsp_pkg.sv
design/hsp_front.sv
design/hsp_queue.sv
design/hsp_back.sv
design/http_status_line_parser.sv
design/hsp_checker.sv
test/http_status_line_parser_test.sv
